/* rtl/sha_pkg.sv */
package sha_pkg;

    localparam int BlockBytes = 64;
    localparam int WordW = 32;
    localparam int CountW = 61;

    typedef logic [WordW-1:0] word_t;

    localparam word_t Iv [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t Kc [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

endpackage

/* rtl/sha_ram.sv */
module sha_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/sha256_byte_stream_hasher.sv */
// channel | dir | tdata                       | tuser      | tlast
// s_axis  | in  | [7:0] data_byte             | byte_valid | message_end
// m_axis  | out | [31:0] digest_word          | word_index | last_word
// Bytes are taken in the idle state while the block fills. The 64th byte,
// or an end request, starts compression: 16 word loads (four byte shifts and
// a round), then 48 schedule rounds (window RAM, one port each way).
// Padding may add a block; 8 digest words go out one per cycle with tready high.
// Input is held off while compressing or while a digest is pending.
// rst_n resets chaining words, fill level and count; RAMs need no clearing.
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // byte_valid
    input  logic        s_axis_tlast,   // message_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [2:0]  st_reg;
    word_t       h_reg [8];
    word_t       v_reg [8];
    logic [5:0]  fill_reg;
    logic [CountW-1:0] cnt_reg;
    logic [6:0]  t_reg;
    logic [2:0]  ph_reg;
    logic        pad_reg;
    logic        final_reg;
    logic        two_reg;
    logic [2:0]  oidx_reg;
    word_t       acc_reg;
    word_t       wa_reg, wb_reg;
    logic        fwd_reg;
    logic [7:0]  fwd_byte_reg;

    logic        bwe;
    logic [5:0]  bwaddr, braddr;
    logic [7:0]  bwdata, brdata;
    logic        swe;
    logic [3:0]  swaddr, sraddr;
    word_t       swdata, srdata;

    sha_ram #(.Width(8), .Depth(BlockBytes)) u_blk (
        .clk(clk), .we(bwe), .waddr(bwaddr), .wdata(bwdata),
        .raddr(braddr), .rdata(brdata));
    sha_ram #(.Width(WordW), .Depth(16)) u_win (
        .clk(clk), .we(swe), .waddr(swaddr), .wdata(swdata),
        .raddr(sraddr), .rdata(srdata));

    logic        acc_in;
    logic [5:0]  fill_nx;
    logic [5:0]  end_fill;
    logic [63:0] bits;
    logic [5:0]  bpos;
    logic [7:0]  padbyte;
    logic [7:0]  rd_byte;
    word_t       w_cur, t1, t2, s0, s1;

    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (st_reg == S_IDLE);
    assign fill_nx = fill_reg + 6'd1;
    assign end_fill = s_axis_tuser ? fill_nx : fill_reg;
    assign bits = {cnt_reg, 3'b000};
    assign rd_byte = fwd_reg ? fwd_byte_reg : brdata;

    // byte at position bpos of the current block, padded when pad_reg is set
    always_comb
    begin
        bpos = {t_reg[3:0], ph_reg[1:0]};
        padbyte = rd_byte;
        if (pad_reg)
        begin
            if (two_reg && !final_reg)
            begin
                padbyte = (bpos < fill_reg) ? rd_byte
                        : (bpos == fill_reg) ? 8'h80 : 8'h00;
            end
            else if (bpos >= 6'd56)
            begin
                padbyte = bits[8*(7 - int'(bpos[2:0])) +: 8];
            end
            else if (two_reg)
            begin
                padbyte = 8'h00;
            end
            else
            begin
                padbyte = (bpos < fill_reg) ? rd_byte
                        : (bpos == fill_reg) ? 8'h80 : 8'h00;
            end
        end
    end

    always_comb
    begin
        s0 = rotr(wb_reg, 7) ^ rotr(wb_reg, 18) ^ (wb_reg >> 3);
        s1 = rotr(wa_reg, 17) ^ rotr(wa_reg, 19) ^ (wa_reg >> 10);
        w_cur = (t_reg < 7'd16) ? acc_reg : acc_reg + srdata;
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + Kc[t_reg[5:0]] + w_cur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb
    begin
        bwe = acc_in && s_axis_tuser;
        bwaddr = fill_reg;
        bwdata = s_axis_tdata;
        braddr = {t_reg[3:0], ph_reg[1:0]};
        swe = 1'b0;
        swaddr = t_reg[3:0];
        swdata = w_cur;
        sraddr = 4'(t_reg - 7'd1);
        if (st_reg == S_RUN)
        begin
            if (t_reg < 7'd16)
            begin
                if (ph_reg == 3'd4)
                begin
                    braddr = {t_reg[3:0] + 4'd1, 2'b00};
                end
                else
                begin
                    braddr = {t_reg[3:0], ph_reg[1:0] + 2'd1};
                end
                swe = (ph_reg == 3'd4);
            end
            else
            begin
                case (ph_reg)
                    3'd0: sraddr = 4'(t_reg - 7'd15);
                    3'd1: sraddr = 4'(t_reg - 7'd7);
                    3'd2: sraddr = t_reg[3:0];
                    default: sraddr = 4'(t_reg - 7'd1);
                endcase
                swe = (ph_reg == 3'd3);
            end
        end
        else if (st_reg == S_IDLE)
        begin
            braddr = 6'd0;
            sraddr = 4'd14;
        end
    end

    // same-cycle write to the address being read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
            fwd_byte_reg <= '0;
        end
        else
        begin
            fwd_reg <= bwe && (bwaddr == braddr);
            fwd_byte_reg <= bwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            for (int i = 0; i < 8; i++) h_reg[i] <= Iv[i];
            for (int i = 0; i < 8; i++) v_reg[i] <= '0;
            fill_reg <= '0;
            cnt_reg <= '0;
            t_reg <= '0;
            ph_reg <= '0;
            pad_reg <= 1'b0;
            final_reg <= 1'b0;
            two_reg <= 1'b0;
            oidx_reg <= '0;
            acc_reg <= '0;
            wa_reg <= '0;
            wb_reg <= '0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (acc_in)
                    begin
                        t_reg <= '0;
                        ph_reg <= '0;
                        for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                        if (s_axis_tuser)
                        begin
                            fill_reg <= fill_nx;
                            cnt_reg <= cnt_reg + CountW'(1);
                        end
                        if (s_axis_tuser && fill_nx == 6'd0)
                        begin
                            // block completes; with an end a pad block follows
                            st_reg <= S_RUN;
                            pad_reg <= 1'b0;
                            two_reg <= 1'b0;
                            final_reg <= s_axis_tlast;
                            oidx_reg <= s_axis_tlast ? 3'd7 : 3'd0;
                        end
                        else if (s_axis_tlast)
                        begin
                            st_reg <= S_RUN;
                            pad_reg <= 1'b1;
                            two_reg <= end_fill > 6'd55;
                            final_reg <= !(end_fill > 6'd55);
                            oidx_reg <= '0;
                        end
                        else
                        begin
                            oidx_reg <= '0;
                        end
                    end
                end
                S_RUN:
                begin
                    if (t_reg < 7'd16)
                    begin
                        if (ph_reg == 3'd4)
                        begin
                            v_reg[7] <= v_reg[6];
                            v_reg[6] <= v_reg[5];
                            v_reg[5] <= v_reg[4];
                            v_reg[4] <= v_reg[3] + t1;
                            v_reg[3] <= v_reg[2];
                            v_reg[2] <= v_reg[1];
                            v_reg[1] <= v_reg[0];
                            v_reg[0] <= t1 + t2;
                            t_reg <= t_reg + 7'd1;
                            ph_reg <= '0;
                        end
                        else
                        begin
                            acc_reg <= {acc_reg[23:0], padbyte};
                            ph_reg <= ph_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        case (ph_reg)
                            3'd0: begin wa_reg <= srdata; ph_reg <= 3'd1; end
                            3'd1: begin wb_reg <= srdata; ph_reg <= 3'd2; end
                            3'd2: begin acc_reg <= s1 + srdata + s0; ph_reg <= 3'd3; end
                            default:
                            begin
                                v_reg[7] <= v_reg[6];
                                v_reg[6] <= v_reg[5];
                                v_reg[5] <= v_reg[4];
                                v_reg[4] <= v_reg[3] + t1;
                                v_reg[3] <= v_reg[2];
                                v_reg[2] <= v_reg[1];
                                v_reg[1] <= v_reg[0];
                                v_reg[0] <= t1 + t2;
                                ph_reg <= '0;
                                t_reg <= t_reg + 7'd1;
                                if (t_reg == 7'd63) st_reg <= S_ADD;
                            end
                        endcase
                    end
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i] + v_reg[i];
                    t_reg <= '0;
                    ph_reg <= '0;
                    if (!pad_reg && oidx_reg == 3'd7)
                    begin
                        // full block then end: run the pure pad block
                        pad_reg <= 1'b1;
                        oidx_reg <= '0;
                        st_reg <= S_RUN;
                    end
                    else if (pad_reg && !final_reg)
                    begin
                        final_reg <= 1'b1;
                        st_reg <= S_RUN;
                    end
                    else if (pad_reg)
                    begin
                        st_reg <= S_OUT;
                        oidx_reg <= '0;
                    end
                    else
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            st_reg <= S_IDLE;
                            for (int i = 0; i < 8; i++) h_reg[i] <= Iv[i];
                            fill_reg <= '0;
                            cnt_reg <= '0;
                            pad_reg <= 1'b0;
                            final_reg <= 1'b0;
                            two_reg <= 1'b0;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (st_reg == S_OUT);
    assign m_axis_tdata  = h_reg[oidx_reg];
    assign m_axis_tuser  = oidx_reg;
    assign m_axis_tlast  = (oidx_reg == 3'd7);
endmodule

/* rtl/sha_checker.sv */
module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("tlast mismatch");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input open while digest out");
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
        |=> (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("word index skip");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("data changed while stalled");
endmodule

bind sha256_byte_stream_hasher sha_checker u_chk (.*);
